/* hdl/bdr_pkg.sv */
// ----------------------------------------------------------------------------
// bdr_pkg
// Shared types, constants and the dither function of the Bayer dither core.
// ----------------------------------------------------------------------------
package bdr_pkg;

	// default geometry
	localparam int LINE_BYTES_DEF  = 40;
	localparam int SCREEN_ROWS_DEF = 240;

	// internal row width, covers screens up to 1024 rows plus offset sums
	localparam int ROW_W = 11;

	// register reset values and word indexes
	localparam logic [7:0] LINES_RST = 8'd210;
	localparam logic       REG_LINES = 1'b0;

	// 4x4 ordered dither thresholds, one row of four per source row phase
	localparam logic [7:0] BAYER [16] = '{
		8'd0,   8'd128, 8'd32,  8'd160,
		8'd192, 8'd64,  8'd224, 8'd96,
		8'd48,  8'd176, 8'd16,  8'd144,
		8'd240, 8'd112, 8'd208, 8'd80
	};

	// one input item after the input register
	typedef struct packed {
		logic [7:0]       pix_byte;
		logic [ROW_W-1:0] dest;
		logic [5:0]       col;
		logic             have_byte;
		logic             row_end;
		logic             frame_end;
		logic             rp_set;
		logic [7:0]       lines;
		logic [ROW_W-1:0] yoff;
	} item_t;

	// one result word
	typedef struct packed {
		logic [7:0] packed_byte;
		logic [7:0] dest_row;
		logic [5:0] out_col;
		logic       range_valid;
		logic [7:0] range_first;
		logic [7:0] range_last;
	} res_t;

	// up to two result words caused by one item
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} push_t;

	// luma is the low nibble times 17, i.e. the nibble repeated
	function automatic logic [7:0] dither4(input logic [3:0] n0, input logic [3:0] n1,
		input logic [3:0] n2, input logic [3:0] n3, input logic [1:0] row);
		logic [7:0] l0, l1, l2, l3;
		logic [7:0] t0, t1, t2, t3;
		logic [7:0] v;
		l0 = {n0, n0};
		l1 = {n1, n1};
		l2 = {n2, n2};
		l3 = {n3, n3};
		t0 = BAYER[{row, 2'd0}];
		t1 = BAYER[{row, 2'd1}];
		t2 = BAYER[{row, 2'd2}];
		t3 = BAYER[{row, 2'd3}];
		v[7] = (l0 >= t0);
		v[6] = (l0 >= t1);
		v[5] = (l1 >= t2);
		v[4] = (l1 >= t3);
		v[3] = (l2 >= t0);
		v[2] = (l2 >= t1);
		v[1] = (l3 >= t2);
		v[0] = (l3 >= t3);
		return v;
	endfunction

endpackage

/* hdl/bdr_cfg.sv */
// ----------------------------------------------------------------------------
// bdr_cfg
// APB register block holding the visible line count.
// ----------------------------------------------------------------------------
module bdr_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  lines_cfg
);

	logic [7:0] lines_q;
	logic       wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	// register write, selected by the word address bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q <= bdr_pkg::LINES_RST;
		end else if (wr && (paddr[2] == bdr_pkg::REG_LINES)) begin
			lines_q <= pwdata[7:0];
		end
	end

	// read back
	assign prdata    = (paddr[2] == bdr_pkg::REG_LINES) ? {24'd0, lines_q} : 32'd0;
	assign lines_cfg = lines_q;

endmodule

/* hdl/bdr_front.sv */
// ----------------------------------------------------------------------------
// bdr_front
// Input register: frame start latch, centring offset, dither and store address.
// ----------------------------------------------------------------------------
module bdr_front #(
	parameter int LINE_BYTES  = bdr_pkg::LINE_BYTES_DEF,
	parameter int SCREEN_ROWS = bdr_pkg::SCREEN_ROWS_DEF,
	parameter int AW          = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [47:0]         s_tdata,
	input  logic                s_tlast,
	input  logic [0:0]          s_tuser,
	input  logic [7:0]          lines_cfg,
	input  logic                clr_busy,
	input  logic                adv1,
	output logic                s1_valid,
	output bdr_pkg::item_t      item_s1,
	output logic [AW-1:0]       rd_addr
);

	localparam int RW = bdr_pkg::ROW_W;
	localparam logic [RW-1:0] SR_W = RW'(SCREEN_ROWS);
	localparam logic [6:0] LB_W    = 7'(LINE_BYTES);
	localparam logic [6:0] LB_LAST = 7'(LINE_BYTES - 1);

	logic           s1_valid_q;
	logic           frame_start_q;
	logic [7:0]     last_lines_q;
	bdr_pkg::item_t item_in;
	logic           accept;
	logic [7:0]     l_new;
	logic [7:0]     lines_eff;
	logic [RW-1:0]  yoff_eff;
	logic [7:0]     src_row;
	logic [5:0]     col;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !clr_busy && (!s1_valid_q || adv1);
	assign src_row  = s_tdata[39:32];
	assign col      = s_tdata[45:40];

	// line count clamp and centring offset, latched view after frame start
	always_comb begin
		l_new     = ({{(RW-8){1'b0}}, lines_cfg} > SR_W) ? SR_W[7:0] : lines_cfg;
		lines_eff = frame_start_q ? l_new : last_lines_q;
		yoff_eff  = (SR_W - {{(RW-8){1'b0}}, lines_eff}) >> 1;
		item_in.pix_byte  = bdr_pkg::dither4(s_tdata[3:0], s_tdata[11:8], s_tdata[19:16],
			s_tdata[27:24], src_row[1:0]);
		item_in.dest      = yoff_eff + {{(RW-8){1'b0}}, src_row};
		item_in.col       = col;
		item_in.have_byte = (src_row < lines_eff) && ({1'b0, col} < LB_W);
		item_in.row_end   = ({1'b0, col} == LB_LAST);
		item_in.frame_end = s_tlast;
		item_in.rp_set    = frame_start_q && ((l_new != last_lines_q) || s_tuser[0]);
		item_in.lines     = lines_eff;
		item_in.yoff      = yoff_eff;
	end

	// frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= 1'b1;
			last_lines_q  <= 8'd0;
			s1_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				if (frame_start_q) begin
					last_lines_q <= l_new;
				end
				frame_start_q <= s_tlast;
				s1_valid_q    <= 1'b1;
			end else if (adv1) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	assign s1_valid = s1_valid_q;
	assign rd_addr  = AW'(32'(item_s1.dest) * 32'(LINE_BYTES) + 32'(item_s1.col));

endmodule

/* hdl/bdr_store.sv */
// ----------------------------------------------------------------------------
// bdr_store
// Previous-frame byte store with write forwarding and a clearing pass.
// ----------------------------------------------------------------------------
module bdr_store #(
	parameter int DEPTH = 9600,
	parameter int AW    = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	output logic [7:0]    rd_data,
	output logic          clr_busy
);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// memory port, a same-edge write is forwarded to the read
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= 8'd0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
		end
	end

	assign rd_data  = rd_q;
	assign clr_busy = clr_busy_q;

endmodule

/* hdl/bdr_track.sv */
// ----------------------------------------------------------------------------
// bdr_track
// Compare stage: row change detection, run tracking and result forming.
// ----------------------------------------------------------------------------
module bdr_track #(
	parameter int SCREEN_ROWS = bdr_pkg::SCREEN_ROWS_DEF,
	parameter int AW          = 14
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s1_valid,
	input  bdr_pkg::item_t item_s1,
	input  logic [AW-1:0]  rd_addr,
	input  logic [7:0]     old_byte,
	input  logic           out_free,
	output logic           adv1,
	output logic           wr_en,
	output logic [AW-1:0]  wr_addr,
	output logic [7:0]     wr_data,
	output logic           load,
	output bdr_pkg::push_t push
);

	localparam int RW = bdr_pkg::ROW_W;
	localparam logic [7:0] FULL_LAST = 8'((SCREEN_ROWS - 1) % 256);

	bdr_pkg::item_t item_s2;
	logic [AW-1:0]  idx_s2;
	logic           s2_valid_q;
	logic           row_diff_q;
	logic           run_open_q;
	logic [7:0]     run_first_q;
	logic           pend_q;

	logic           adv2;
	logic           rp, rd, ro;
	logic           open_now, close_now;
	logic           run_open_mid;
	logic [7:0]     run_first_mid;
	logic           fe_run, fe_rep;
	logic [RW-1:0]  end_sum;
	logic [7:0]     close_last;
	bdr_pkg::res_t  rng_a, rng_b, byte_res;
	logic [1:0]     nrng;
	logic [1:0]     nres;

	// row and run decisions for the item in this stage
	always_comb begin
		rp            = pend_q || item_s2.rp_set;
		rd            = row_diff_q || (item_s2.have_byte && (old_byte != item_s2.pix_byte));
		ro            = item_s2.have_byte && item_s2.row_end;
		open_now      = ro && (rp || rd) && !run_open_q;
		close_now     = ro && !(rp || rd) && run_open_q;
		run_open_mid  = open_now || (run_open_q && !close_now);
		run_first_mid = open_now ? item_s2.dest[7:0] : run_first_q;
		fe_run        = item_s2.frame_end && run_open_mid;
		fe_rep        = item_s2.frame_end && rp;
		end_sum       = item_s2.yoff + {{(RW-8){1'b0}}, item_s2.lines} - 1'b1;
		close_last    = item_s2.dest[7:0] - 8'd1;
	end

	// ranges in emission order: closed run, run at frame end, full repaint
	always_comb begin
		rng_a = '0;
		rng_b = '0;
		rng_a.range_valid = close_now || fe_run || fe_rep;
		if (close_now) begin
			rng_a.range_first = run_first_q;
			rng_a.range_last  = close_last;
		end else if (fe_run) begin
			rng_a.range_first = run_first_mid;
			rng_a.range_last  = end_sum[7:0];
		end else if (fe_rep) begin
			rng_a.range_first = 8'd0;
			rng_a.range_last  = FULL_LAST;
		end
		if ((close_now || fe_run) && fe_rep) begin
			rng_b.range_valid = 1'b1;
			rng_b.range_first = 8'd0;
			rng_b.range_last  = FULL_LAST;
		end
		nrng = {1'b0, rng_a.range_valid} + {1'b0, rng_b.range_valid};
	end

	// result words, the pixel word carries the first range
	always_comb begin
		byte_res             = rng_a;
		byte_res.packed_byte = item_s2.pix_byte;
		byte_res.dest_row    = item_s2.dest[7:0];
		byte_res.out_col     = item_s2.col;
		if (item_s2.have_byte) begin
			push.r0  = byte_res;
			push.r1  = rng_b;
			push.two = rng_b.range_valid;
			nres     = 2'd1 + {1'b0, rng_b.range_valid};
		end else begin
			push.r0  = rng_a;
			push.r1  = rng_b;
			push.two = rng_b.range_valid;
			nres     = nrng;
		end
	end

	// stage handshake
	assign adv2    = s2_valid_q && ((nres == 2'd0) || out_free);
	assign adv1    = s1_valid && (!s2_valid_q || adv2);
	assign load    = adv2 && (nres != 2'd0);
	assign wr_en   = adv2 && item_s2.have_byte;
	assign wr_addr = idx_s2;
	assign wr_data = item_s2.pix_byte;

	// tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			row_diff_q  <= 1'b0;
			run_open_q  <= 1'b0;
			run_first_q <= 8'd0;
			pend_q      <= 1'b1;
		end else begin
			if (adv1) begin
				s2_valid_q <= 1'b1;
			end else if (adv2) begin
				s2_valid_q <= 1'b0;
			end
			if (adv2) begin
				run_first_q <= run_first_mid;
				if (item_s2.frame_end) begin
					row_diff_q <= 1'b0;
					run_open_q <= 1'b0;
					pend_q     <= 1'b0;
				end else begin
					row_diff_q <= rd && !ro;
					run_open_q <= run_open_mid;
					pend_q     <= rp;
				end
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv1) begin
			item_s2 <= item_s1;
			idx_s2  <= rd_addr;
		end
	end

endmodule

/* hdl/bdr_out.sv */
// ----------------------------------------------------------------------------
// bdr_out
// Output register, sends the one or two result words of an item in order.
// ----------------------------------------------------------------------------
module bdr_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  bdr_pkg::push_t push,
	output logic           out_free,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [39:0]    m_tdata,
	output logic [0:0]     m_tuser,
	output logic           m_tlast
);

	bdr_pkg::push_t push_q;
	bdr_pkg::res_t  cur;
	logic           o_valid_q;
	logic           o_k_q;
	logic           take;
	logic           done;

	assign take     = o_valid_q && m_tready;
	assign m_tlast  = o_k_q || !push_q.two;
	assign done     = take && m_tlast;
	assign out_free = !o_valid_q || done;

	// word sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			o_k_q     <= 1'b0;
		end else if (load) begin
			o_valid_q <= 1'b1;
			o_k_q     <= 1'b0;
		end else if (done) begin
			o_valid_q <= 1'b0;
		end else if (take) begin
			o_k_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			push_q <= push;
		end
	end

	// current word onto the bus
	assign cur      = o_k_q ? push_q.r1 : push_q.r0;
	assign m_tvalid = o_valid_q;
	assign m_tdata  = {2'b00, cur.range_last, cur.range_first, cur.out_col, cur.dest_row,
		cur.packed_byte};
	assign m_tuser  = cur.range_valid;

endmodule

/* hdl/bayer_dither_row_diff_core.sv */
// ----------------------------------------------------------------------------
// bayer_dither_row_diff_core
// 4x4 ordered dither to 1-bit bytes with previous-frame compare and dirty-row
// range reporting.
// ----------------------------------------------------------------------------
// Path: input register, compare stage, then output register for the result words.
// Throughput: one item per cycle while the output is not stalled; an item with
// two result words holds the output register until both are taken. Rate is set
// by one frame store read and one write per item, the read as it enters the
// compare stage, the write as it leaves. Reset: control state clears at once,
// then a clearing pass writes all SCREEN_ROWS*LINE_BYTES store bytes (9600 by default) with s_tready low.
module bayer_dither_row_diff_core #(
	parameter int LINE_BYTES  = bdr_pkg::LINE_BYTES_DEF,
	parameter int SCREEN_ROWS = bdr_pkg::SCREEN_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // pixel0, pixel1, pixel2, pixel3, src_row, byte_col, pad
	input  logic        s_tlast,  // frame_end
	input  logic [0:0]  s_tuser,  // repaint_request
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // packed_byte, dest_row, out_col, range_first, range_last, pad
	output logic [0:0]  m_tuser,  // range_valid
	output logic        m_tlast,  // last
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DEPTH = SCREEN_ROWS * LINE_BYTES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic           [7:0]    lines_cfg;
	logic                    clr_busy;
	logic                    adv1;
	logic                    s1_valid;
	bdr_pkg::item_t          item_s1;
	logic           [AW-1:0] rd_addr;
	logic           [7:0]    old_byte;
	logic                    wr_en;
	logic           [AW-1:0] wr_addr;
	logic           [7:0]    wr_data;
	logic                    load;
	bdr_pkg::push_t          push;
	logic                    out_free;

	bdr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.lines_cfg (lines_cfg)
	);

	bdr_front #(
		.LINE_BYTES  (LINE_BYTES),
		.SCREEN_ROWS (SCREEN_ROWS),
		.AW          (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.lines_cfg (lines_cfg),
		.clr_busy  (clr_busy),
		.adv1      (adv1),
		.s1_valid  (s1_valid),
		.item_s1   (item_s1),
		.rd_addr   (rd_addr)
	);

	bdr_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (adv1),
		.rd_addr  (rd_addr),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_data  (old_byte),
		.clr_busy (clr_busy)
	);

	bdr_track #(
		.SCREEN_ROWS (SCREEN_ROWS),
		.AW          (AW)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.item_s1  (item_s1),
		.rd_addr  (rd_addr),
		.old_byte (old_byte),
		.out_free (out_free),
		.adv1     (adv1),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.load     (load),
		.push     (push)
	);

	bdr_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.push     (push),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* hdl/bdr_chk.sv */
// ----------------------------------------------------------------------------
// bdr_chk
// Port-level checks on the result stream of the dither core.
// ----------------------------------------------------------------------------
module bdr_chk #(
	parameter int LINE_BYTES = bdr_pkg::LINE_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result word changed while stalled");

	// a word without a range has zero range fields
	a_norange: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[37:22] == 16'd0)
		else $error("range fields set without range");

	// only range-carrying words are followed by a second word
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[0])
		else $error("non-final word without range");

	// byte column stays inside the line
	a_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> {1'b0, m_tdata[21:16]} < 7'(LINE_BYTES))
		else $error("output column out of line");

endmodule

bind bayer_dither_row_diff_core bdr_chk #(.LINE_BYTES(LINE_BYTES)) u_bdr_chk (.*);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the Bayer dither core: a directed table, then random
// frames over several line counts and stall patterns. Every result word is
// checked against the table's typed words or an in-bench model of the dither,
// frame compare and dirty-range logic.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_LEN = bdr_pkg::LINE_BYTES_DEF;
	localparam int SCREEN_H = bdr_pkg::SCREEN_ROWS_DEF;
	localparam logic [2:0] LINES_ADDR = {bdr_pkg::REG_LINES, 2'b00};
	localparam int THRESH [16] = '{
		0,   128, 32,  160,
		192, 64,  224, 96,
		48,  176, 16,  144,
		240, 112, 208, 80
	};
	localparam int DIR_N = 16;

	// one input word
	typedef struct packed {
		logic [31:0] pix;      // pixel3 .. pixel0
		logic [7:0]  row;
		logic [5:0]  col;
		logic        fend;
		logic        repaint;
	} pix_item_t;

	// one result word
	typedef struct packed {
		logic [7:0] pbyte;
		logic [7:0] dest;
		logic [5:0] col;
		logic       rng_valid;
		logic [7:0] rng_first;
		logic [7:0] rng_last;
		logic       last;
	} dither_word_t;

	// directed row: typed < 0 takes the model's words
	typedef struct {
		pix_item_t    item;
		int           typed;
		dither_word_t w0;
		dither_word_t w1;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // pixel0, pixel1, pixel2, pixel3, src_row, byte_col, pad
	logic        s_tlast = 1'b0; // frame_end
	logic [0:0]  s_tuser = '0;   // repaint_request
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // packed_byte, dest_row, out_col, range_first, range_last, pad
	logic [0:0]  m_tuser;        // range_valid
	logic        m_tlast;        // last
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// model state, at its reset values
	bit [7:0]    screen_copy [SCREEN_H * LINE_LEN];
	bit          row_dirty = 1'b0;
	bit          run_active = 1'b0;
	logic [7:0]  run_top = '0;
	bit          need_full = 1'b1;
	logic [7:0]  latched_lines = '0;
	bit          frame_begin = 1'b1;
	logic [7:0]  lines_shadow = bdr_pkg::LINES_RST;

	bit [31:0]    pix_hist [SCREEN_H * LINE_LEN];
	dither_word_t pending_words [$];
	int           bytes_predicted = 0;
	int           fail_count = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           hold_off_cycles = 0;

	// lines 210 after reset, so rows start at display row 15
	directed_row_t dir_tab [DIR_N] = '{
		// first frame is a forced repaint
		'{'{32'h0000_0000, 8'd0, 6'd0, 1'b0, 1'b0}, 1,
			'{8'h88, 8'd15, 6'd0, 1'b0, 8'd0, 8'd0, 1'b1}, '0},
		'{'{32'hFFFF_FFFF, 8'd0, 6'd39, 1'b0, 1'b0}, 1,
			'{8'hFF, 8'd15, 6'd39, 1'b0, 8'd0, 8'd0, 1'b1}, '0},
		// last visible row ends the frame: open run then full screen
		'{'{32'hF0F0_F0F0, 8'd209, 6'd39, 1'b1, 1'b0}, 2,
			'{8'h00, 8'd224, 6'd39, 1'b1, 8'd15, 8'd224, 1'b0},
			'{8'h00, 8'd0, 6'd0, 1'b1, 8'd0, 8'd239, 1'b1}},
		// dropped row on a one-word frame
		'{'{32'hA5A5_A5A5, 8'd210, 6'd0, 1'b1, 1'b0}, 0, '0, '0},
		// repaint request on a dropped column
		'{'{32'h1234_5678, 8'd0, 6'd50, 1'b0, 1'b1}, 0, '0, '0},
		'{'{32'h0F0F_0F0F, 8'd0, 6'd39, 1'b0, 1'b0}, 1,
			'{8'hFF, 8'd15, 6'd39, 1'b0, 8'd0, 8'd0, 1'b1}, '0},
		// request in mid-frame is ignored
		'{'{32'h7E3C_1A69, 8'd1, 6'd39, 1'b0, 1'b1}, -1, '0, '0},
		'{'{32'h8888_8888, 8'd2, 6'd39, 1'b1, 1'b0}, 2,
			'{8'hAA, 8'd17, 6'd39, 1'b1, 8'd15, 8'd224, 1'b0},
			'{8'h00, 8'd0, 6'd0, 1'b1, 8'd0, 8'd239, 1'b1}},
		// unchanged frame except row 1
		'{'{32'h0F0F_0F0F, 8'd0, 6'd39, 1'b0, 1'b0}, 1,
			'{8'hFF, 8'd15, 6'd39, 1'b0, 8'd0, 8'd0, 1'b1}, '0},
		'{'{32'h0000_0005, 8'd1, 6'd0, 1'b0, 1'b0}, -1, '0, '0},
		'{'{32'h7E3C_1A69, 8'd1, 6'd39, 1'b0, 1'b0}, -1, '0, '0},
		'{'{32'h8888_8888, 8'd2, 6'd39, 1'b0, 1'b0}, 1,
			'{8'hAA, 8'd17, 6'd39, 1'b1, 8'd16, 8'd16, 1'b1}, '0},
		'{'{32'hFFFF_FFFF, 8'd255, 6'd63, 1'b1, 1'b0}, 0, '0, '0},
		// rows out of order, run still open at frame end
		'{'{32'h0000_0000, 8'd3, 6'd39, 1'b0, 1'b0}, -1, '0, '0},
		'{'{32'h3333_3333, 8'd5, 6'd39, 1'b0, 1'b0}, -1, '0, '0},
		'{'{32'h1111_1111, 8'd4, 6'd39, 1'b1, 1'b0}, -1, '0, '0}
	};

	bayer_dither_row_diff_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 125 MHz clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void log_fail(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("mismatch: %s", msg);
		end
	endfunction

	function automatic string word_text(input dither_word_t w);
		return $sformatf("byte=%h row=%0d col=%0d rv=%b range=%0d..%0d last=%b",
			w.pbyte, w.dest, w.col, w.rng_valid, w.rng_first, w.rng_last, w.last);
	endfunction

	// each source pixel covers two output bits, thresholds t0 t1 t2 t3 repeat
	function automatic logic [7:0] dither_byte(input logic [31:0] pix, input logic [1:0] ph);
		logic [7:0] v;
		int luma;
		for (int b = 0; b < 8; b++) begin
			luma = pix[8 * (b / 2) +: 4] * 17;
			v[7 - b] = (luma >= THRESH[ph * 4 + b % 4]);
		end
		return v;
	endfunction

	// dither, frame compare and range tracking for one accepted word
	task automatic dither_predict(input pix_item_t it, output dither_word_t words[$]);
		logic [7:0] rf [2];
		logic [7:0] rl [2];
		logic [7:0] pb;
		dither_word_t w;
		int nr, k, lines, yoff, dest, idx;
		nr = 0;
		words = {};
		if (frame_begin) begin
			lines = (lines_shadow > SCREEN_H) ? SCREEN_H : int'(lines_shadow);
			if (lines != latched_lines || it.repaint) need_full = 1'b1;
			latched_lines = 8'(lines);
			frame_begin = 1'b0;
		end
		lines = int'(latched_lines);
		yoff = (SCREEN_H - lines) / 2;
		dest = yoff + it.row;
		// visible byte: compare with the stored frame, close rows at the last column
		if (it.row < lines && it.col < LINE_LEN) begin
			idx = dest * LINE_LEN + it.col;
			pb = dither_byte(it.pix, it.row[1:0]);
			bytes_predicted++;
			if (screen_copy[idx] != pb) row_dirty = 1'b1;
			screen_copy[idx] = pb;
			if (it.col == LINE_LEN - 1) begin
				if (need_full || row_dirty) begin
					if (!run_active) begin
						run_active = 1'b1;
						run_top = dest[7:0];
					end
				end else if (run_active) begin
					rf[nr] = run_top;
					rl[nr] = 8'(dest - 1);
					nr++;
					run_active = 1'b0;
				end
				row_dirty = 1'b0;
			end
			w = '0;
			w.pbyte = pb;
			w.dest = dest[7:0];
			w.col = it.col;
			words.push_back(w);
		end
		// frame end flushes the open run and the full-screen repaint
		if (it.fend) begin
			if (run_active && nr < 2) begin
				rf[nr] = run_top;
				rl[nr] = 8'(yoff + lines - 1);
				nr++;
			end
			if (need_full && nr < 2) begin
				rf[nr] = 8'd0;
				rl[nr] = 8'(SCREEN_H - 1);
				nr++;
			end
			need_full = 1'b0;
			run_active = 1'b0;
			row_dirty = 1'b0;
			frame_begin = 1'b1;
		end
		k = 0;
		if (words.size() > 0 && nr > 0) begin
			words[0].rng_valid = 1'b1;
			words[0].rng_first = rf[0];
			words[0].rng_last = rl[0];
			k = 1;
		end
		for (; k < nr; k++) begin
			w = '0;
			w.rng_valid = 1'b1;
			w.rng_first = rf[k];
			w.rng_last = rl[k];
			words.push_back(w);
		end
		if (words.size() > 0) words[words.size() - 1].last = 1'b1;
	endtask

	// drive one word until accepted, then run the model on it
	task automatic send_item(input pix_item_t it, output dither_word_t words[$]);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {2'b00, it.col, it.row, it.pix};
		s_tlast <= it.fend;
		s_tuser <= it.repaint;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		dither_predict(it, words);
	endtask

	task automatic offer(input pix_item_t it);
		dither_word_t words [$];
		send_item(it, words);
		foreach (words[i]) pending_words.push_back(words[i]);
	endtask

	// stop sending and let every expected word drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == LINES_ADDR) lines_shadow = val[7:0];
	endtask

	task automatic reg_check(input logic [2:0] addr, input logic [7:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[7:0] !== want) begin
			log_fail($sformatf("register %0d exp %0d got %0d", addr, want, prdata[7:0]));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// one random frame: mostly a run of rows in order, sometimes a broken sequence
	task automatic frame_burst(input int lines);
		int rows [$];
		int cols [$];
		int first_row, nrows, mode, c, n, r;
		bit opening;
		pix_item_t it;
		logic [31:0] old;
		rows = {};
		opening = 1'b1;
		if ($urandom_range(99) < 20) begin
			// broken frame: stray rows and columns, early frame ends
			n = $urandom_range(2, 10);
			for (int k = 0; k < n; k++) begin
				case ($urandom_range(9))
					0, 1, 2: r = 0;
					3, 4, 5, 6: r = $urandom_range(lines - 1);
					default: r = $urandom_range(255);
				endcase
				case ($urandom_range(9))
					0, 1, 2, 3, 4: c = LINE_LEN - 1;
					5, 6, 7: c = $urandom_range(LINE_LEN - 1);
					default: c = $urandom_range(63);
				endcase
				it.pix = $urandom;
				if (r < SCREEN_H && c < LINE_LEN) begin
					if ($urandom_range(1)) it.pix = pix_hist[r * LINE_LEN + c];
					pix_hist[r * LINE_LEN + c] = it.pix;
				end
				it.row = 8'(r);
				it.col = 6'(c);
				it.fend = (k == n - 1) || ($urandom_range(99) < 10);
				it.repaint = ($urandom_range(99) < 20);
				offer(it);
			end
		end else begin
			if (lines <= 8) begin
				for (int i = 0; i < lines; i++) rows.push_back(i);
			end else begin
				first_row = $urandom_range(lines - 1);
				nrows = $urandom_range(1, 5);
				for (int i = first_row; i < lines && i < first_row + nrows; i++) rows.push_back(i);
			end
			foreach (rows[i]) begin
				// row kept, touched only in ignored high nibbles, or new
				mode = $urandom_range(99);
				cols = {};
				if ($urandom_range(99) < 20) begin
					for (int k = 0; k < LINE_LEN; k++) cols.push_back(k);
				end else begin
					c = 0;
					repeat ($urandom_range(3)) begin
						c = $urandom_range(c, LINE_LEN - 2);
						cols.push_back(c);
					end
					cols.push_back(LINE_LEN - 1);
				end
				foreach (cols[j]) begin
					// occasional word outside the visible area
					if ($urandom_range(99) < 5) begin
						it.pix = $urandom;
						it.fend = 1'b0;
						it.repaint = ($urandom_range(99) < 10);
						if ($urandom_range(1)) begin
							it.row = 8'($urandom_range(255, lines));
							it.col = 6'($urandom_range(63));
						end else begin
							it.row = 8'(rows[i]);
							it.col = 6'($urandom_range(63, LINE_LEN));
						end
						offer(it);
						opening = 1'b0;
					end
					old = pix_hist[rows[i] * LINE_LEN + cols[j]];
					if (mode < 50) it.pix = old;
					else if (mode < 65) it.pix = old ^ ($urandom & 32'hF0F0_F0F0);
					else it.pix = $urandom;
					pix_hist[rows[i] * LINE_LEN + cols[j]] = it.pix;
					it.row = 8'(rows[i]);
					it.col = 6'(cols[j]);
					it.fend = (i == rows.size() - 1) && (j == cols.size() - 1);
					it.repaint = ($urandom_range(99) < (opening ? 10 : 5));
					offer(it);
					opening = 1'b0;
				end
			end
		end
	endtask

	// result side: random stalls, long hold-off on request, compare in order
	initial begin : result_sink
		dither_word_t got;
		dither_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.pbyte = m_tdata[7:0];
				got.dest = m_tdata[15:8];
				got.col = m_tdata[21:16];
				got.rng_first = m_tdata[29:22];
				got.rng_last = m_tdata[37:30];
				got.rng_valid = m_tuser[0];
				got.last = m_tlast;
				if (pending_words.size() == 0) begin
					log_fail({"unexpected word ", word_text(got)});
				end else begin
					want = pending_words.pop_front();
					if (got !== want) begin
						log_fail({"exp ", word_text(want), " got ", word_text(got)});
					end
				end
			end
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
				hold_off_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int phase_lines [10] = '{1, 240, 3, 2, 5, 1, 240, 4, 0, 6};
		int lines, base;
		dither_word_t words [$];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		reg_check(LINES_ADDR, bdr_pkg::LINES_RST);

		// directed table at the reset line count
		for (int i = 0; i < DIR_N; i++) begin
			send_item(dir_tab[i].item, words);
			if (dir_tab[i].typed < 0) begin
				foreach (words[j]) pending_words.push_back(words[j]);
			end else begin
				if (dir_tab[i].typed > 0) pending_words.push_back(dir_tab[i].w0);
				if (dir_tab[i].typed > 1) pending_words.push_back(dir_tab[i].w1);
			end
		end
		settle();

		// random phases, each with its own line count and stall pattern
		for (int p = 0; p < 10; p++) begin
			lines = (phase_lines[p] == 0) ? $urandom_range(240, 1) : phase_lines[p];
			reg_write(LINES_ADDR, lines);
			reg_check(LINES_ADDR, 8'(lines));
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 72;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 72;
				end
				default: begin
					send_idle_pct = 7;
					recv_stall_pct = 7;
				end
			endcase
			if (p == 4) hold_off_cycles = 400;
			base = bytes_predicted;
			while (bytes_predicted - base < 125) frame_burst(lines);
			settle();
		end

		if (fail_count == 0 && pending_words.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/bdr_pkg.sv
hdl/bdr_cfg.sv
hdl/bdr_front.sv
hdl/bdr_store.sv
hdl/bdr_track.sv
hdl/bdr_out.sv
hdl/bayer_dither_row_diff_core.sv
hdl/bdr_chk.sv
verif/tb_top.sv
